### hdl/l2tk_pkg.sv
// Shared constants, types and helpers for the brute-force top-k search core.
package l2tk_pkg;

  localparam int unsigned MaxVectors = 1024;
  localparam int unsigned MaxDim     = 64;
  localparam int unsigned MaxTopK    = 16;

  localparam int unsigned IdW    = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned DimW   = 7;
  localparam int unsigned PosW   = 6;
  localparam int unsigned KW     = 5;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned SqW    = 40;
  localparam int unsigned DistW  = 20;
  localparam int unsigned RankW  = 4;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic CfgDimension = 1'b0;
  localparam logic CfgTopK      = 1'b1;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // controller -> datapath
  typedef struct packed {
    logic       scan_start;   // clear accumulator, start first vector
    logic       scan_elem;    // process one element (memory read issued)
    logic       scan_end;     // last element of a vector: finish distance
    logic       sqrt_start;   // start root of slot rank
    logic       rank_next;    // advance output rank
  } l2tk_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       ins_busy;
    logic       sqrt_busy;
    logic       last_vec;
    logic       last_elem;
    logic       last_rank;
  } l2tk_sts_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) r = DimW'(1);
    else if (d > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  function automatic logic [KW-1:0] eff_k(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    r = k;
    if (k == '0) r = KW'(1);
    else if (k > KW'(MaxTopK)) r = KW'(MaxTopK);
    return r;
  endfunction

endpackage

### hdl/l2_brute_force_topk_search_core.sv
// Top level of the brute-force k-nearest-neighbor search core.
// Input channel s_axis: tdata[0] opcode (0 add, 1 query), tdata[16:1] element
//   value (signed Q8.8). One beat per element.
// Config channel cfg_*: index 0 dimension, 1 top_k; write only while idle.
// Output channel m_axis: tdata = id, distance, rank; tuser = none_found; tlast
//   marks the final result of a query.
// The final query beat starts a scan of every stored element, one element
//   per cycle through the store memory port, but the last element of a vector
//   waits while the list insertion of the previous vector runs. After the last
//   vector the first root starts once the StDrain countdown has run out and
//   the list insertion has ended. Each result then passes StRoot, StWait for
//   its square root, and StEmit. An empty store goes to StEmpty after the
//   final beat and loads its single result there.
// While a query runs s_axis_tready is low. A stalled receiver holds the
//   result register; the next result waits until the register is free.
// Reset empties the store and restores dimension 16 and top_k 4.
module l2_brute_force_topk_search_core import l2tk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [0] opcode, [16:1] elem_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [9:0] result_id, [29:10] distance, [33:30] rank
  output logic        m_axis_tuser,   // [0] none_found
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [DimW-1:0] dim_q;
  logic [KW-1:0]   k_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimW'(16);
      k_q   <= KW'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgDimension: dim_q <= cfg_data[DimW-1:0];
        CfgTopK:      k_q   <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  l2tk_cmd_t cmd;
  l2tk_sts_t sts;
  logic in_fire, qdone, empty, out_load, out_none, out_last, out_free;
  logic [IdW-1:0]   r_id;
  logic [DistW-1:0] r_dist;
  logic [RankW-1:0] r_rank;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  l2tk_datapath u_dp (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .in_op_i   (s_axis_tdata[0]),
    .in_val_i  (s_axis_tdata[16:1]),
    .dim_i     (dim_q),
    .k_i       (k_q),
    .query_done_o (qdone),
    .empty_o   (empty),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_id_o  (r_id),
    .res_dist_o(r_dist),
    .res_rank_o(r_rank)
  );

  l2tk_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .query_done_i (qdone),
    .empty_i      (empty),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .in_ready_o   (s_axis_tready),
    .out_load_o   (out_load),
    .out_none_o   (out_none),
    .out_last_o   (out_last),
    .out_free_i   (out_free)
  );

  logic out_v_q;
  logic [39:0] out_data_q;
  logic out_user_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (out_load) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_none ? 40'd0 : {6'd0, r_rank, r_dist, r_id};
      out_user_q <= out_none;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready)) else $error("result overwritten");
  a_busy_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !out_load) else $error("load while stalled");
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast) else $error("none_found not last");
`endif
endmodule

### hdl/l2tk_isqrt.sv
// Bit-pair iterative integer square root, one result bit per cycle.
module l2tk_isqrt import l2tk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   x_i,
  output logic             busy_o,
  output logic [DistW-1:0] root_o
);
  logic [SqW-1:0]   rem_q, rem_d;
  logic [SqW-1:0]   res_q, res_d;
  logic [SqW-1:0]   bit_q, bit_d;
  logic             busy_q, busy_d;
  logic [SqW:0]     trial;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    if (start_i) begin
      rem_d  = x_i;
      res_d  = '0;
      bit_d  = SqW'(1) << (SqW - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[SqW-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = (res_q[SqW-1:DistW] != '0) ? DistMax : res_q[DistW-1:0];
endmodule

### hdl/l2tk_datapath.sv
// Datapath: vector store, query buffer, distance accumulator, sorted list, root.
module l2tk_datapath import l2tk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beat
  input  logic             in_fire_i,
  input  logic             in_op_i,
  input  logic [15:0]      in_val_i,
  input  logic [DimW-1:0]  dim_i,
  input  logic [KW-1:0]    k_i,
  output logic             query_done_o,
  output logic             empty_o,
  // control
  input  l2tk_cmd_t        cmd_i,
  output l2tk_sts_t        sts_o,
  // result
  output logic [IdW-1:0]   res_id_o,
  output logic [DistW-1:0] res_dist_o,
  output logic [RankW-1:0] res_rank_o
);
  logic [DimW-1:0] dim;
  logic [KW-1:0]   kk;
  assign dim = eff_dim(dim_i);
  assign kk  = eff_k(k_i);

  logic [15:0] store_mem [MaxVectors*MaxDim];
  logic [15:0] qbuf_mem  [MaxDim];

  logic [CntW-1:0] count_q;
  logic [DimW-1:0] add_pos_q, qry_pos_q;
  logic [DimW-1:0] add_pos, qry_pos;

  assign add_pos = (add_pos_q >= dim) ? dim - DimW'(1) : add_pos_q;
  assign qry_pos = (qry_pos_q >= dim) ? dim - DimW'(1) : qry_pos_q;

  logic add_fire, qry_fire, add_done, qry_done, full;
  assign add_fire = in_fire_i && (in_op_i == OpAdd);
  assign qry_fire = in_fire_i && (in_op_i == OpQuery);
  assign add_done = (add_pos + DimW'(1)) >= dim;
  assign qry_done = (qry_pos + DimW'(1)) >= dim;
  assign full     = (count_q == CntW'(MaxVectors));
  assign query_done_o = qry_fire && qry_done;
  assign empty_o  = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      add_pos_q <= '0;
      qry_pos_q <= '0;
    end else begin
      if (add_fire) begin
        add_pos_q <= add_done ? '0 : add_pos + DimW'(1);
        if (add_done && !full) count_q <= count_q + CntW'(1);
      end
      if (qry_fire) qry_pos_q <= qry_done ? '0 : qry_pos + DimW'(1);
    end
  end

  // scan counters
  logic [IdW-1:0]  vid_q;
  logic [PosW-1:0] eidx_q;
  logic [15:0]     st_rd_q, qb_rd_q;
  logic            rd_v_q, end_v_q;
  logic [IdW-1:0]  rd_id_q;

  always_ff @(posedge clk_i) begin
    if (add_fire && !full)
      store_mem[{count_q[IdW-1:0], add_pos[PosW-1:0]}] <= in_val_i;
    if (qry_fire) qbuf_mem[qry_pos[PosW-1:0]] <= in_val_i;
    st_rd_q <= store_mem[{vid_q, eidx_q}];
    qb_rd_q <= qbuf_mem[eidx_q];
  end

  assign sts_o.last_elem = ({1'b0, eidx_q} + DimW'(1)) >= dim;
  assign sts_o.last_vec  = ({1'b0, vid_q} + CntW'(1)) >= count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_q   <= '0;
      eidx_q  <= '0;
      rd_v_q  <= 1'b0;
      end_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.scan_elem;
      end_v_q <= cmd_i.scan_elem && cmd_i.scan_end;
      if (cmd_i.scan_start) begin
        vid_q  <= '0;
        eidx_q <= '0;
      end else if (cmd_i.scan_elem) begin
        if (cmd_i.scan_end) begin
          eidx_q <= '0;
          vid_q  <= vid_q + IdW'(1);
        end else begin
          eidx_q <= eidx_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_elem) rd_id_q <= vid_q;
  end

  // difference, square, accumulate: registered stages
  logic signed [16:0] diff_q;
  logic               sq_v_q, sq_end_q, acc_v_q, acc_end_q;
  logic [33:0]        sq_q;
  logic [SqW-1:0]     acc_q, fin_q;
  logic [IdW-1:0]     id1_q, id2_q, fin_id_q;
  logic               fin_v_q;
  logic [16:0]        mag;

  assign mag = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0; sq_end_q <= 1'b0; acc_v_q <= 1'b0; acc_end_q <= 1'b0;
      fin_v_q <= 1'b0;
    end else begin
      sq_v_q   <= rd_v_q;
      sq_end_q <= end_v_q;
      acc_v_q  <= sq_v_q;
      acc_end_q <= sq_end_q;
      fin_v_q  <= acc_v_q && acc_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= 17'($signed(qb_rd_q)) - 17'($signed(st_rd_q));
    id1_q  <= rd_id_q;
    sq_q   <= 34'(mag) * 34'(mag);
    id2_q  <= id1_q;
    if (cmd_i.scan_start) acc_q <= '0;
    else if (acc_v_q) acc_q <= acc_end_q ? '0 : acc_q + SqW'(sq_q);
    if (acc_v_q && acc_end_q) begin
      fin_q    <= acc_q + SqW'(sq_q);
      fin_id_q <= id2_q;
    end
  end

  // sorted list: insertion one slot per cycle from the tail
  logic [SqW-1:0] best_d [MaxTopK];
  logic [IdW-1:0] best_i [MaxTopK];
  logic [KW-1:0]  filled_q;
  logic [KW-1:0]  ipos_q;
  logic           ins_q;
  logic [SqW-1:0] nd_q;
  logic [IdW-1:0] nid_q;

  // busy from the end of a vector in the pipe until its insertion is done
  assign sts_o.ins_busy = ins_q || fin_v_q || end_v_q || sq_end_q ||
                          (acc_v_q && acc_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q    <= 1'b0;
      filled_q <= '0;
      ipos_q   <= '0;
    end else begin
      if (cmd_i.scan_start) filled_q <= '0;
      if (fin_v_q) begin
        if (filled_q == kk && fin_q >= best_d[SlotW'(kk - KW'(1))]) begin
          ins_q <= 1'b0;
        end else begin
          ins_q  <= 1'b1;
          ipos_q <= (filled_q < kk) ? filled_q : kk - KW'(1);
          if (filled_q < kk) filled_q <= filled_q + KW'(1);
        end
      end else if (ins_q) begin
        if (ipos_q != '0 && best_d[SlotW'(ipos_q - KW'(1))] > nd_q) begin
          ipos_q <= ipos_q - KW'(1);
        end else begin
          ins_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_v_q) begin
      nd_q  <= fin_q;
      nid_q <= fin_id_q;
    end
    if (ins_q) begin
      if (ipos_q != '0 && best_d[SlotW'(ipos_q - KW'(1))] > nd_q) begin
        best_d[SlotW'(ipos_q)] <= best_d[SlotW'(ipos_q - KW'(1))];
        best_i[SlotW'(ipos_q)] <= best_i[SlotW'(ipos_q - KW'(1))];
      end else begin
        best_d[SlotW'(ipos_q)] <= nd_q;
        best_i[SlotW'(ipos_q)] <= nid_q;
      end
    end
  end

  // output rank and root
  logic [RankW-1:0] rank_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rank_q <= '0;
    else if (cmd_i.scan_start) rank_q <= '0;
    else if (cmd_i.rank_next) rank_q <= rank_q + RankW'(1);
  end

  assign sts_o.last_rank = (KW'(rank_q) + KW'(1)) >= filled_q;

  l2tk_isqrt u_isqrt (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.sqrt_start),
    .x_i     (best_d[rank_q]),
    .busy_o  (sts_o.sqrt_busy),
    .root_o  (res_dist_o)
  );

  assign res_id_o   = best_i[rank_q];
  assign res_rank_o = rank_q;
endmodule

### hdl/l2tk_ctrl.sv
// Controller: sequences the scan, drains insertion and emits ranked results.
module l2tk_ctrl import l2tk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      query_done_i,
  input  logic      empty_i,
  input  l2tk_sts_t sts_i,
  output l2tk_cmd_t cmd_o,
  output logic      in_ready_o,
  output logic      out_load_o,
  output logic      out_none_o,
  output logic      out_last_o,
  input  logic      out_free_i
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StRoot  = 3'd3;
  localparam logic [2:0] StWait  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;
  localparam logic [2:0] StEmpty = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] drain_q, drain_d;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    cmd_o   = '0;
    out_load_o = 1'b0;
    out_none_o = 1'b0;
    out_last_o = 1'b0;
    in_ready_o = (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        if (query_done_i) begin
          cmd_o.scan_start = 1'b1;
          state_d = empty_i ? StEmpty : StScan;
        end
      end
      StScan: begin
        // hold off the last element of a vector while insertion of the previous one runs
        if (!(sts_i.last_elem && sts_i.ins_busy)) begin
          cmd_o.scan_elem = 1'b1;
          if (sts_i.last_elem) begin
            cmd_o.scan_end  = 1'b1;
            if (sts_i.last_vec) begin
              state_d = StDrain;
              drain_d = 3'd6;
            end
          end
        end
      end
      StDrain: begin
        if (drain_q != '0) drain_d = drain_q - 3'd1;
        else if (!sts_i.ins_busy) state_d = StRoot;
      end
      StRoot: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = StWait;
      end
      StWait: begin
        if (!sts_i.sqrt_busy) state_d = StEmit;
      end
      StEmit: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          out_last_o = sts_i.last_rank;
          if (sts_i.last_rank) begin
            state_d = StIdle;
          end else begin
            cmd_o.rank_next = 1'b1;
            state_d = StRoot;
          end
        end
      end
      StEmpty: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          out_none_o = 1'b1;
          out_last_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end
endmodule
